// File: rtl/keypad_matrix_scanner_macros.svh
// Assertion macros for the keypad matrix scanner.
// Included by the top level; no other dependencies.
`ifndef KEYPAD_MATRIX_SCANNER_MACROS_SVH
`define KEYPAD_MATRIX_SCANNER_MACROS_SVH
`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle
`define KMS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("keypad scanner check failed");
// Antecedent implies consequent in the next cycle
`define KMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("keypad scanner check failed");
`else
`define KMS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define KMS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/kms_pkg.sv
// Shared types, constants and helper functions of the keypad matrix scanner.
// No dependencies; used by kms_core and keypad_matrix_scanner.
package kms_pkg;

    // Configuration port
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_NUMBER_MODE  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DIGIT_COUNT  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SETTLE       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_POLL = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_IDLE_RETRY   = 3'd4;

    // Register reset values
    localparam logic        NUMBER_MODE_RESET  = 1'b0;
    localparam logic [3:0]  DIGIT_COUNT_RESET  = 4'd4;
    localparam logic [7:0]  SETTLE_RESET       = 8'd25;
    localparam logic [23:0] RELEASE_POLL_RESET = 24'd100000;
    localparam logic [23:0] IDLE_RETRY_RESET   = 24'd50000;

    // Output field widths
    localparam int KEY_INDEX_W = 4;
    localparam int KEY_ASCII_W = 7;
    localparam int NUMBER_W    = 30;

    // Special keys and their characters
    localparam logic [7:0] KEY_STAR = 8'd10;
    localparam logic [7:0] KEY_ZERO = 8'd11;
    localparam logic [7:0] KEY_HASH = 8'd12;
    localparam logic [7:0] KEY_MAX_DIGIT = 8'd9;
    localparam logic [KEY_ASCII_W-1:0] ASCII_ZERO = 7'h30;
    localparam logic [KEY_ASCII_W-1:0] ASCII_STAR = 7'h2A;
    localparam logic [KEY_ASCII_W-1:0] ASCII_HASH = 7'h23;

    localparam logic [3:0] DIGITS_MIN = 4'd1;
    localparam logic [3:0] DIGITS_MAX = 4'd9;

    typedef struct packed {
        logic        number_mode;
        logic [3:0]  digit_count;
        logic [7:0]  settle_ticks;
        logic [23:0] release_poll_ticks;
        logic [23:0] idle_retry_ticks;
    } kms_cfg_t;

    typedef enum logic [2:0] {
        PH_IDLE_SETTLE = 3'd0,
        PH_SCAN_SETTLE = 3'd1,
        PH_REL_SETTLE  = 3'd2,
        PH_REL_POLL    = 3'd3,
        PH_RETRY       = 3'd4
    } kms_phase_t;

    // Clamp the digit count into 1..9
    function automatic logic [3:0] eff_digits(input logic [3:0] cnt);
        logic [3:0] r;
        if (cnt == 4'd0) begin
            r = DIGITS_MIN;
        end else if (cnt > DIGITS_MAX) begin
            r = DIGITS_MAX;
        end else begin
            r = cnt;
        end
        return r;
    endfunction

    // Character for a key position; zero for unknown keys
    function automatic logic [KEY_ASCII_W-1:0] key_ascii(input logic [7:0] k);
        logic [KEY_ASCII_W-1:0] r;
        if (k <= KEY_MAX_DIGIT) begin
            r = ASCII_ZERO + KEY_ASCII_W'(k);
        end else if (k == KEY_STAR) begin
            r = ASCII_STAR;
        end else if (k == KEY_ZERO) begin
            r = ASCII_ZERO;
        end else if (k == KEY_HASH) begin
            r = ASCII_HASH;
        end else begin
            r = '0;
        end
        return r;
    endfunction

endpackage

// File: rtl/kms_core.sv
// Scan sequencer of the keypad matrix scanner: phase FSM, wait counter,
// key decode and number accumulation. Depends on kms_pkg.
module kms_core #(
    parameter int NUM_COLS   = 3,
    parameter int NUM_ROWS   = 4,
    parameter int WAIT_WIDTH = 24
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  kms_pkg::kms_cfg_t                   cfg,
    input  logic                                digit_reload,
    input  logic [3:0]                          digit_reload_count,
    input  logic                                advance,
    input  logic [NUM_ROWS-1:0]                 rows,
    output logic [NUM_COLS-1:0]                 col_drive,
    output logic                                key_valid,
    output logic [kms_pkg::KEY_INDEX_W-1:0]     key_index,
    output logic [kms_pkg::KEY_ASCII_W-1:0]     key_ascii,
    output logic                                number_valid,
    output logic [kms_pkg::NUMBER_W-1:0]        number_value
);

    localparam int COL_W = (NUM_COLS > 1) ? $clog2(NUM_COLS) : 1;
    localparam int ROW_W = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int KEY_W = $clog2(NUM_ROWS * NUM_COLS + 1);
    localparam int NW    = kms_pkg::NUMBER_W;

    // Wait load: truncate to the counter, zero counts as one
    function automatic logic [WAIT_WIDTH-1:0] load_wait(
        input logic [kms_pkg::CFG_DATA_W-1:0] v
    );
        logic [WAIT_WIDTH-1:0] t;
        t = WAIT_WIDTH'(v);
        return (t == '0) ? WAIT_WIDTH'(1) : t;
    endfunction

    kms_pkg::kms_phase_t   phase_reg, phase_next;
    logic [COL_W-1:0]      scan_column_reg, scan_column_next;
    logic [WAIT_WIDTH-1:0] wait_count_reg, wait_count_next;
    logic [KEY_W-1:0]      held_key_reg, held_key_next;
    logic [NW-1:0]         number_acc_reg, number_acc_next;
    logic [3:0]            digits_left_reg, digits_left_next;

    logic [ROW_W-1:0]      first_row;
    logic [KEY_W-1:0]      hit_key;
    logic [7:0]            key_wide;
    logic                  expired;
    logic                  report;
    logic                  is_digit;
    logic [3:0]            digit_val;
    logic [NW-1:0]         acc_times_ten;

    // Lowest set row wins
    always_comb begin
        first_row = '0;
        for (int r = NUM_ROWS - 1; r >= 0; r--) begin
            if (rows[r]) begin
                first_row = ROW_W'(r);
            end
        end
    end

    assign hit_key = KEY_W'(int'(first_row) * NUM_COLS + int'(scan_column_reg) + 1);

    // Held key as a digit
    assign key_wide      = 8'(held_key_reg);
    assign is_digit      = (key_wide <= kms_pkg::KEY_MAX_DIGIT) ||
                           (key_wide == kms_pkg::KEY_ZERO);
    assign digit_val     = (key_wide == kms_pkg::KEY_ZERO) ? 4'd0 : key_wide[3:0];
    assign acc_times_ten = (number_acc_reg << 3) + (number_acc_reg << 1) + NW'(digit_val);

    assign expired = (wait_count_reg <= WAIT_WIDTH'(1));

    // Next state and this tick's outputs
    always_comb begin
        phase_next       = phase_reg;
        scan_column_next = scan_column_reg;
        wait_count_next  = wait_count_reg;
        held_key_next    = held_key_reg;
        number_acc_next  = number_acc_reg;
        digits_left_next = digits_left_reg;
        report           = 1'b0;
        key_valid        = 1'b0;
        key_index        = '0;
        key_ascii        = '0;
        number_valid     = 1'b0;
        number_value     = '0;

        col_drive = '1;
        if (phase_reg == kms_pkg::PH_SCAN_SETTLE) begin
            col_drive = NUM_COLS'(1) << scan_column_reg;
        end

        if (!expired) begin
            wait_count_next = wait_count_reg - WAIT_WIDTH'(1);
        end else begin
            case (phase_reg)
                kms_pkg::PH_IDLE_SETTLE: begin
                    if (rows != '0) begin
                        phase_next       = kms_pkg::PH_SCAN_SETTLE;
                        scan_column_next = '0;
                        wait_count_next  = load_wait(24'(cfg.settle_ticks));
                    end else begin
                        phase_next      = kms_pkg::PH_RETRY;
                        wait_count_next = load_wait(cfg.idle_retry_ticks);
                    end
                end
                kms_pkg::PH_SCAN_SETTLE: begin
                    if (rows != '0) begin
                        held_key_next   = hit_key;
                        phase_next      = kms_pkg::PH_REL_SETTLE;
                        wait_count_next = load_wait(24'(cfg.settle_ticks));
                    end else if (int'(scan_column_reg) + 1 < NUM_COLS) begin
                        scan_column_next = scan_column_reg + COL_W'(1);
                        wait_count_next  = load_wait(24'(cfg.settle_ticks));
                    end else begin
                        phase_next      = kms_pkg::PH_RETRY;
                        wait_count_next = load_wait(cfg.idle_retry_ticks);
                    end
                end
                kms_pkg::PH_REL_SETTLE, kms_pkg::PH_REL_POLL: begin
                    if (rows == '0) begin
                        report = 1'b1;
                    end else begin
                        phase_next      = kms_pkg::PH_REL_POLL;
                        wait_count_next = load_wait(cfg.release_poll_ticks);
                    end
                end
                default: begin
                    phase_next      = kms_pkg::PH_IDLE_SETTLE;
                    wait_count_next = load_wait(24'(cfg.settle_ticks));
                end
            endcase
        end

        // Key release: report the key or fold it into the number
        if (report) begin
            if (!cfg.number_mode) begin
                key_valid = 1'b1;
                key_index = key_wide[kms_pkg::KEY_INDEX_W-1:0];
                key_ascii = kms_pkg::key_ascii(key_wide);
            end else if (is_digit) begin
                number_acc_next = acc_times_ten;
                if (digits_left_reg > 4'd1) begin
                    digits_left_next = digits_left_reg - 4'd1;
                end else begin
                    number_valid     = 1'b1;
                    number_value     = acc_times_ten;
                    number_acc_next  = '0;
                    digits_left_next = kms_pkg::eff_digits(cfg.digit_count);
                end
            end
            held_key_next    = '0;
            scan_column_next = '0;
            phase_next       = kms_pkg::PH_IDLE_SETTLE;
            wait_count_next  = load_wait(24'(cfg.settle_ticks));
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= kms_pkg::PH_IDLE_SETTLE;
            scan_column_reg <= '0;
            wait_count_reg  <= load_wait(24'(kms_pkg::SETTLE_RESET));
            held_key_reg    <= '0;
            number_acc_reg  <= '0;
            digits_left_reg <= kms_pkg::eff_digits(kms_pkg::DIGIT_COUNT_RESET);
        end else if (digit_reload) begin
            number_acc_reg  <= '0;
            digits_left_reg <= kms_pkg::eff_digits(digit_reload_count);
        end else if (advance) begin
            phase_reg       <= phase_next;
            scan_column_reg <= scan_column_next;
            wait_count_reg  <= wait_count_next;
            held_key_reg    <= held_key_next;
            number_acc_reg  <= number_acc_next;
            digits_left_reg <= digits_left_next;
        end
    end

endmodule

// File: rtl/keypad_matrix_scanner.sv
// Keypad matrix scanner top level: configuration registers, scan sequencer
// and output register. Depends on kms_pkg, kms_core and the macros header.
//
// Usage: each transaction on the s_ channel is one tick carrying the sampled
// row lines; each tick yields exactly one transaction on the m_ channel with
// the column drive for that tick and, on a key release, the key report or a
// completed number. Configuration is written through cfg_wr_en, cfg_index and
// cfg_wdata while no tick is in flight.
// m_tvalid rises the cycle after s_ acceptance. Throughput: one tick per cycle
// unless the receiver stalls; the sequencer is a single registered pass with
// one wait counter. A new tick is taken while the previous result is being
// taken, so the output register is the only buffer between the two sides.
// Reset (aresetn low, synchronous) loads the register defaults, puts the
// sequencer in the idle settle phase and empties the output register.
// When the receiver stalls, the result holds and s_tready drops until the
// result is taken; the scan state only advances on accepted ticks.
`include "keypad_matrix_scanner_macros.svh"

module keypad_matrix_scanner #(
    parameter int NUM_COLS   = 3,
    parameter int NUM_ROWS   = 4,
    parameter int WAIT_WIDTH = 24,
    localparam int S_DATA_W  = ((NUM_ROWS + 7) / 8) * 8,
    localparam int M_DATA_W  = ((NUM_COLS + 41 + 7) / 8) * 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration write port
    input  logic                               cfg_wr_en,
    input  logic [kms_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [kms_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // Row sample input
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [S_DATA_W-1:0]                s_tdata,   // row_sense
    // Result output
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [M_DATA_W-1:0]                m_tdata,   // col_drive, key_index,
                                                          // key_ascii, number_value
    output logic [1:0]                         m_tuser    // key_valid, number_valid
);

    kms_pkg::kms_cfg_t cfg_reg;

    logic                               s_accept;
    logic                               digit_reload;
    logic [NUM_COLS-1:0]                col_drive_next;
    logic                               key_valid_next;
    logic [kms_pkg::KEY_INDEX_W-1:0]    key_index_next;
    logic [kms_pkg::KEY_ASCII_W-1:0]    key_ascii_next;
    logic                               number_valid_next;
    logic [kms_pkg::NUMBER_W-1:0]       number_value_next;

    logic                               m_tvalid_reg;
    logic [NUM_COLS-1:0]                col_drive_reg;
    logic                               key_valid_reg;
    logic [kms_pkg::KEY_INDEX_W-1:0]    key_index_reg;
    logic [kms_pkg::KEY_ASCII_W-1:0]    key_ascii_reg;
    logic                               number_valid_reg;
    logic [kms_pkg::NUMBER_W-1:0]       number_value_reg;

    // Handshake: take a tick whenever the output register frees up
    assign s_tready     = !m_tvalid_reg || m_tready;
    assign s_accept     = s_tvalid && s_tready;
    assign digit_reload = cfg_wr_en && (cfg_index == kms_pkg::REG_DIGIT_COUNT);

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.number_mode        <= kms_pkg::NUMBER_MODE_RESET;
            cfg_reg.digit_count        <= kms_pkg::DIGIT_COUNT_RESET;
            cfg_reg.settle_ticks       <= kms_pkg::SETTLE_RESET;
            cfg_reg.release_poll_ticks <= kms_pkg::RELEASE_POLL_RESET;
            cfg_reg.idle_retry_ticks   <= kms_pkg::IDLE_RETRY_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                kms_pkg::REG_NUMBER_MODE:  cfg_reg.number_mode        <= cfg_wdata[0];
                kms_pkg::REG_DIGIT_COUNT:  cfg_reg.digit_count        <= cfg_wdata[3:0];
                kms_pkg::REG_SETTLE:       cfg_reg.settle_ticks       <= cfg_wdata[7:0];
                kms_pkg::REG_RELEASE_POLL: cfg_reg.release_poll_ticks <= cfg_wdata;
                kms_pkg::REG_IDLE_RETRY:   cfg_reg.idle_retry_ticks   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    kms_core #(
        .NUM_COLS   (NUM_COLS),
        .NUM_ROWS   (NUM_ROWS),
        .WAIT_WIDTH (WAIT_WIDTH)
    ) u_core (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg                (cfg_reg),
        .digit_reload       (digit_reload),
        .digit_reload_count (cfg_wdata[3:0]),
        .advance            (s_accept),
        .rows               (s_tdata[NUM_ROWS-1:0]),
        .col_drive          (col_drive_next),
        .key_valid          (key_valid_next),
        .key_index          (key_index_next),
        .key_ascii          (key_ascii_next),
        .number_valid       (number_valid_next),
        .number_value       (number_value_next)
    );

    // Output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            col_drive_reg    <= col_drive_next;
            key_valid_reg    <= key_valid_next;
            key_index_reg    <= key_index_next;
            key_ascii_reg    <= key_ascii_next;
            number_valid_reg <= number_valid_next;
            number_value_reg <= number_value_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_DATA_W'({number_value_reg, key_ascii_reg, key_index_reg,
                                 col_drive_reg});
    assign m_tuser  = {number_valid_reg, key_valid_reg};

    // Checks
    `KMS_ASSERT_NEXT(a_accept_gives_result, aclk, aresetn, s_accept, m_tvalid_reg)
    `KMS_ASSERT_IMP(a_one_report_kind, aclk, aresetn, m_tvalid_reg, !(key_valid_reg && number_valid_reg))
    `KMS_ASSERT_IMP(a_report_drives_all, aclk, aresetn, m_tvalid_reg && (key_valid_reg || number_valid_reg), col_drive_reg == {NUM_COLS{1'b1}})
    `KMS_ASSERT_IMP(a_key_only_in_key_mode, aclk, aresetn, m_tvalid_reg && key_valid_reg, !cfg_reg.number_mode)

endmodule
